// ----- rtl/rbp_pkg.sv -----
package rbp_pkg;

  // Fixed field widths of the ports.
  localparam int unsigned COORD_BITS = 13;
  localparam int unsigned SIZE_BITS  = 13;
  localparam int unsigned BORD_BITS  = 3;
  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned COUNT_BITS = 12;
  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned CFG_DATA_BITS = 13;

  // Parameter defaults.
  localparam int unsigned DEF_MAX_INNER_WIDTH  = 4096;
  localparam int unsigned DEF_MAX_INNER_HEIGHT = 4096;
  localparam int unsigned DEF_MAX_BORDER       = 7;
  localparam int unsigned DEF_PIXEL_BITS       = 16;

  // Register reset values.
  localparam logic [SIZE_BITS-1:0] RST_INNER_WIDTH  = 13'd64;
  localparam logic [SIZE_BITS-1:0] RST_INNER_HEIGHT = 13'd64;
  localparam logic [BORD_BITS-1:0] RST_BORDER       = 3'd0;

  // Smallest inner size that the block works with.
  localparam logic [SIZE_BITS-1:0] MIN_SIZE = 13'd2;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_INNER_WIDTH  = 2'd0,
    REG_INNER_HEIGHT = 2'd1,
    REG_BORDER_X     = 2'd2,
    REG_BORDER_Y     = 2'd3
  } cfg_reg_t;

  // One classified pixel: the rectangle of writes it causes.
  typedef struct packed {
    logic [COORD_BITS-1:0] x0;
    logic [COORD_BITS-1:0] x1;
    logic [COORD_BITS-1:0] y0;
    logic [COORD_BITS-1:0] y1;
    logic [VALUE_BITS-1:0] value;
    logic                  frame_end;
  } cmd_t;

  // Push side of the command queue.
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_push_t;

endpackage

// ----- rtl/rbp_front.sv -----
module rbp_front #(
  parameter int unsigned MAX_INNER_WIDTH  = rbp_pkg::DEF_MAX_INNER_WIDTH,
  parameter int unsigned MAX_INNER_HEIGHT = rbp_pkg::DEF_MAX_INNER_HEIGHT,
  parameter int unsigned MAX_BORDER       = rbp_pkg::DEF_MAX_BORDER,
  parameter int unsigned PIXEL_BITS       = rbp_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rbp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [rbp_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                  in_valid,
  input  logic signed [rbp_pkg::VALUE_BITS-1:0] in_pixel_in,
  input  logic                                  queue_full,
  output rbp_pkg::cmd_push_t                    push
);

  localparam int unsigned SB = rbp_pkg::SIZE_BITS;
  localparam int unsigned CB = rbp_pkg::COORD_BITS;
  localparam int unsigned NB = rbp_pkg::COUNT_BITS;
  localparam int unsigned VB = rbp_pkg::VALUE_BITS;
  localparam int unsigned BB = rbp_pkg::BORD_BITS;
  localparam int unsigned SIZE_LIMIT = (1 << SB) - 1;
  localparam logic [SB-1:0] MAX_W =
    (MAX_INNER_WIDTH > SIZE_LIMIT) ? SB'(SIZE_LIMIT) : SB'(MAX_INNER_WIDTH);
  localparam logic [SB-1:0] MAX_H =
    (MAX_INNER_HEIGHT > SIZE_LIMIT) ? SB'(SIZE_LIMIT) : SB'(MAX_INNER_HEIGHT);
  localparam logic [BB-1:0] MAX_B = BB'(MAX_BORDER);

  logic [SB-1:0] inner_width_r, inner_height_r;
  logic [BB-1:0] border_x_r, border_y_r;
  logic [NB-1:0] column_count_r, column_count_nxt;
  logic [NB-1:0] row_count_r, row_count_nxt;

  logic [SB-1:0] w_eff, h_eff;
  logic [BB-1:0] bx, by;
  logic [CB-1:0] c_ext, r_ext, xc, yr;
  logic          last_col, last_row, accept;
  logic [VB-1:0] pix_mask;

  // Configuration registers are written at any enabled edge.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inner_width_r  <= rbp_pkg::RST_INNER_WIDTH;
      inner_height_r <= rbp_pkg::RST_INNER_HEIGHT;
      border_x_r     <= rbp_pkg::RST_BORDER;
      border_y_r     <= rbp_pkg::RST_BORDER;
    end else if (cfg_we) begin
      case (rbp_pkg::cfg_reg_t'(cfg_index))
        rbp_pkg::REG_INNER_WIDTH:  inner_width_r  <= cfg_wdata;
        rbp_pkg::REG_INNER_HEIGHT: inner_height_r <= cfg_wdata;
        rbp_pkg::REG_BORDER_X:     border_x_r     <= cfg_wdata[BB-1:0];
        rbp_pkg::REG_BORDER_Y:     border_y_r     <= cfg_wdata[BB-1:0];
        default: ;
      endcase
    end
  end

  // Clamp sizes and borders into their working range.
  always_comb begin
    w_eff = inner_width_r;
    if (inner_width_r < rbp_pkg::MIN_SIZE) w_eff = rbp_pkg::MIN_SIZE;
    else if (inner_width_r > MAX_W) w_eff = MAX_W;
    h_eff = inner_height_r;
    if (inner_height_r < rbp_pkg::MIN_SIZE) h_eff = rbp_pkg::MIN_SIZE;
    else if (inner_height_r > MAX_H) h_eff = MAX_H;
    bx = (border_x_r > MAX_B) ? MAX_B : border_x_r;
    by = (border_y_r > MAX_B) ? MAX_B : border_y_r;
  end

  // Keep only the pixel bits that the source drives.
  always_comb begin
    for (int i = 0; i < VB; i++) begin
      pix_mask[i] = (i < PIXEL_BITS);
    end
  end

  // Classify the pixel and work out the rectangle of writes it covers.
  always_comb begin
    c_ext    = CB'(column_count_r);
    r_ext    = CB'(row_count_r);
    last_col = c_ext >= (w_eff - 1'b1);
    last_row = r_ext >= (h_eff - 1'b1);
    xc       = c_ext + CB'(bx);
    yr       = r_ext + CB'(by);
    push.valid         = accept;
    push.cmd.x0        = (column_count_r == '0) ? '0 : xc;
    push.cmd.x1        = last_col ? xc + CB'(bx) : xc;
    push.cmd.y0        = (row_count_r == '0) ? '0 : yr;
    push.cmd.y1        = last_row ? yr + CB'(by) : yr;
    push.cmd.value     = in_pixel_in & pix_mask;
    push.cmd.frame_end = last_col && last_row;
  end

  assign accept = in_valid && !queue_full;

  // Raster position of the next pixel.
  always_comb begin
    column_count_nxt = column_count_r;
    row_count_nxt    = row_count_r;
    if (accept) begin
      if (last_col) begin
        column_count_nxt = '0;
        row_count_nxt    = last_row ? '0 : row_count_r + 1'b1;
      end else begin
        column_count_nxt = column_count_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      column_count_r <= '0;
      row_count_r    <= '0;
    end else begin
      column_count_r <= column_count_nxt;
      row_count_r    <= row_count_nxt;
    end
  end

endmodule

// ----- rtl/rbp_queue.sv -----
module rbp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  rbp_pkg::cmd_push_t push,
  input  logic               pop,
  output logic               full,
  output logic               head_valid,
  output rbp_pkg::cmd_t      head
);

  localparam int unsigned DEPTH = rbp_pkg::QUEUE_DEPTH;
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned NW = $clog2(DEPTH + 1);

  rbp_pkg::cmd_t entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full       = (count_r == NW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = entry_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill count update, wrapping at the depth.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) count_nxt = count_r + 1'b1;
    else if (do_pop && !do_push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

// ----- rtl/rbp_back.sv -----
module rbp_back (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  head_valid,
  input  rbp_pkg::cmd_t                         head,
  output logic                                  pop,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rbp_pkg::COORD_BITS-1:0]        out_x,
  output logic [rbp_pkg::COORD_BITS-1:0]        out_y,
  output logic signed [rbp_pkg::VALUE_BITS-1:0] out_value,
  output logic                                  out_last_of_item,
  output logic                                  out_frame_done
);

  localparam int unsigned CB = rbp_pkg::COORD_BITS;

  rbp_pkg::cmd_t cur_r, cur_nxt;
  logic          active_r, active_nxt;
  logic [CB-1:0] x_r, x_nxt, y_r, y_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [CB-1:0] out_x_r, out_y_r;
  logic [rbp_pkg::VALUE_BITS-1:0] out_value_r;
  logic          out_last_r, out_frame_r;
  logic          load, fin;

  // The output register takes a new write when empty or being drained.
  assign load = !out_valid_r || !out_stall;
  assign fin  = (x_r == cur_r.x1) && (y_r == cur_r.y1);
  assign pop  = head_valid && (!active_r || (load && fin));

  // Walk the rectangle row by row, chaining into the next command.
  always_comb begin
    cur_nxt       = cur_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    active_nxt    = active_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = active_r;
      if (active_r) begin
        if (x_r == cur_r.x1) begin
          x_nxt = cur_r.x0;
          y_nxt = y_r + 1'b1;
        end else begin
          x_nxt = x_r + 1'b1;
        end
        if (fin) active_nxt = 1'b0;
      end
    end
    if (pop) begin
      cur_nxt    = head;
      x_nxt      = head.x0;
      y_nxt      = head.y0;
      active_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    if (load && active_r) begin
      out_x_r     <= x_r;
      out_y_r     <= y_r;
      out_value_r <= cur_r.value;
      out_last_r  <= fin;
      out_frame_r <= fin && cur_r.frame_end;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_value        = out_value_r;
  assign out_last_of_item = out_last_r;
  assign out_frame_done   = out_frame_r;

endmodule

// ----- rtl/replicate_border_pad.sv -----
// Edge-replicating border padding for a streamed image.
// Input channel: in_valid / in_stall with in_pixel_in, one inner pixel per
// transfer in raster order. Output channel: out_valid / out_stall with a
// write command (out_x, out_y, out_value) into the padded frame, plus
// out_last_of_item on the final write of a pixel and out_frame_done on the
// final write of the frame. Sizes and borders come through the cfg_ port
// and are to be written by the user only while the block is idle; the
// block itself does not enforce this. An interior pixel gives one write,
// an edge pixel a row or column of border copies, a corner pixel up to
// 8 x 8 writes. The back end issues one write per cycle while out_stall
// does not hold it. The first write of a pixel passes through the command
// queue, the back end's command register and the output register.
// A two-entry command queue sits between the classifying front end and
// the write generator; in_stall rises only when that queue is full.
// When out_stall is high the pending write holds and the generator waits.
// Reset clears the raster position, the queue and the output valid, and
// loads the registers with width 64, height 64 and no borders.
module replicate_border_pad #(
  parameter int unsigned MAX_INNER_WIDTH  = rbp_pkg::DEF_MAX_INNER_WIDTH,
  parameter int unsigned MAX_INNER_HEIGHT = rbp_pkg::DEF_MAX_INNER_HEIGHT,
  parameter int unsigned MAX_BORDER       = rbp_pkg::DEF_MAX_BORDER,
  parameter int unsigned PIXEL_BITS       = rbp_pkg::DEF_PIXEL_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [rbp_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [rbp_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [rbp_pkg::VALUE_BITS-1:0] in_pixel_in,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [rbp_pkg::COORD_BITS-1:0]        out_x,
  output logic [rbp_pkg::COORD_BITS-1:0]        out_y,
  output logic signed [rbp_pkg::VALUE_BITS-1:0] out_value,
  output logic                                  out_last_of_item,
  output logic                                  out_frame_done
);

  rbp_pkg::cmd_push_t push;
  rbp_pkg::cmd_t      head;
  logic               queue_full, head_valid, pop;

  assign in_stall = queue_full;

  // Front end: configuration, raster position and classification.
  rbp_front #(
    .MAX_INNER_WIDTH  (MAX_INNER_WIDTH),
    .MAX_INNER_HEIGHT (MAX_INNER_HEIGHT),
    .MAX_BORDER       (MAX_BORDER),
    .PIXEL_BITS       (PIXEL_BITS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_pixel_in (in_pixel_in),
    .queue_full  (queue_full),
    .push        (push)
  );

  // Command queue between the two halves.
  rbp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  // Back end: write generation and output register.
  rbp_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_x            (out_x),
    .out_y            (out_y),
    .out_value        (out_value),
    .out_last_of_item (out_last_of_item),
    .out_frame_done   (out_frame_done)
  );

endmodule

// ----- rtl/rbp_checker.sv -----
module rbp_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic [rbp_pkg::COORD_BITS-1:0]        out_x,
  input logic [rbp_pkg::COORD_BITS-1:0]        out_y,
  input logic signed [rbp_pkg::VALUE_BITS-1:0] out_value,
  input logic                                  out_last_of_item,
  input logic                                  out_frame_done
);

  // A stalled write keeps its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_value) && $stable(out_last_of_item) && $stable(out_frame_done))
    else $error("stalled write changed");

  // The end of a frame is also the end of its pixel.
  a_frame_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_last_of_item)
    else $error("frame end without item end");

  // Writes of one pixel follow each other without a gap.
  a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_item |=> out_valid)
    else $error("gap inside the writes of a pixel");

  // Reset leaves the queue empty and no write pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("state not cleared by reset");

endmodule

bind replicate_border_pad rbp_checker u_rbp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_x            (out_x),
  .out_y            (out_y),
  .out_value        (out_value),
  .out_last_of_item (out_last_of_item),
  .out_frame_done   (out_frame_done)
);
